// ----- rtl/core/w2l_pkg.sv -----
// ----------------------------------------------------------------------------
// w2l_pkg
// Shared widths, types and register codes of the world-to-local transform.
// ----------------------------------------------------------------------------
package w2l_pkg;

  // Coordinate and coefficient formats
  localparam int COORD_WIDTH = 40;               // signed Q19.20
  localparam int COORD_FRAC  = 20;
  localparam int COEFF_WIDTH = 21;               // signed Q2.(COEFF_WIDTH-3)
  localparam int COEFF_FRAC  = COEFF_WIDTH - 3;
  localparam int SLOT_WIDTH  = 21;               // coefficient slot in a row register
  localparam int ROW_WIDTH   = 3 * SLOT_WIDTH;
  localparam int THR_WIDTH   = 20;

  // Configuration port
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;

  // Datapath widths
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;           // p - o
  localparam int PROD_WIDTH = DIFF_WIDTH + COEFF_WIDTH;  // c * (p - o)
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;            // three products
  localparam int RND_WIDTH  = SUM_WIDTH - COEFF_FRAC;    // rounded to 20 fraction bits
  localparam int SNAP_WIDTH = RND_WIDTH + 1;             // after snapping up

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [RND_WIDTH-1:0]   rnd_t;
  typedef logic signed [SNAP_WIDTH-1:0]  snap_t;
  typedef logic [ROW_WIDTH-1:0]          row_t;
  typedef logic [THR_WIDTH-1:0]          thr_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0     = 3'd0,
    REG_ROW1     = 3'd1,
    REG_ROW2     = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_ORIGIN_Z = 3'd5,
    REG_THRESH   = 3'd6
  } cfg_reg_e;

  // Identity row: 1.0 in slot r
  function automatic row_t identity_row(input int unsigned r);
    row_t row;
    row = '0;
    row[SLOT_WIDTH*r +: COEFF_WIDTH] = COEFF_WIDTH'(1) << COEFF_FRAC;
    return row;
  endfunction

endpackage

// ----- rtl/core/world_to_local_point_transform.sv -----
// ----------------------------------------------------------------------------
// world_to_local_point_transform
// Local coordinates of a world point: L = M * (P - O), rounded, snapped to
// whole numbers within a threshold and saturated to the coordinate range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one world point per word,
//   output channel (out_valid_o / out_ready_i) one local point plus a
//   saturated flag. Configuration goes through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i and must only be written while no point is in flight.
//   An accepted point passes through four register stages: difference,
//   products, sum and round, snap and saturate. Throughput: one point per
//   cycle while the receiver does not stall, set by the fully pipelined
//   multiply stage with nine independent multipliers.
//   Every stage keeps its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles close up and the input keeps accepting while
//   a finished result waits. When the receiver stalls the pipeline fills, and
//   in_ready_o drops only once all four stages hold a word.
//   Reset clears all valid bits and loads the identity matrix, a zero origin
//   and a snap threshold of one LSB.
// ----------------------------------------------------------------------------
module world_to_local_point_transform
  import w2l_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  // input points
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] world_x_i,
  input  logic signed [COORD_WIDTH-1:0] world_y_i,
  input  logic signed [COORD_WIDTH-1:0] world_z_i,
  // output points
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_WIDTH-1:0] local_x_o,
  output logic signed [COORD_WIDTH-1:0] local_y_o,
  output logic signed [COORD_WIDTH-1:0] local_z_o,
  output logic                      saturated_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  row_t   row_q    [3];
  coord_t origin_q [3];
  thr_t   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        row_q[r]    <= identity_row(r);
        origin_q[r] <= '0;
      end
      thr_q <= THR_WIDTH'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROW0:     row_q[0]    <= cfg_wdata_i[ROW_WIDTH-1:0];
        REG_ROW1:     row_q[1]    <= cfg_wdata_i[ROW_WIDTH-1:0];
        REG_ROW2:     row_q[2]    <= cfg_wdata_i[ROW_WIDTH-1:0];
        REG_ORIGIN_X: origin_q[0] <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_THRESH:   thr_q       <= cfg_wdata_i[THR_WIDTH-1:0];
        default:      ; // unused index: drop the write
      endcase
    end
  end

  // Unpack coefficients
  coeff_t coeff [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coeff[r][k] = row_q[r][SLOT_WIDTH*k +: COEFF_WIDTH];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its successor moves
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_go, s2_go, s3_go, out_go;

  assign out_go     = !out_valid_q || out_ready_i;
  assign s3_go      = !s3_valid_q  || out_go;
  assign s2_go      = !s2_valid_q  || s3_go;
  assign s1_go      = !s1_valid_q  || s2_go;
  assign in_ready_o = s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_go)  s1_valid_q  <= in_valid_i;
      if (s2_go)  s2_valid_q  <= s1_valid_q;
      if (s3_go)  s3_valid_q  <= s2_valid_q;
      if (out_go) out_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: subtract the origin
  // --------------------------------------------------------------------------
  coord_t world [3];
  diff_t  diff_d [3];
  diff_t  diff_q [3];

  assign world[0] = world_x_i;
  assign world[1] = world_y_i;
  assign world[2] = world_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_d[k] = DIFF_WIDTH'(world[k]) - DIFF_WIDTH'(origin_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && in_valid_i) diff_q <= diff_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: nine coefficient products
  // --------------------------------------------------------------------------
  prod_t prod_d [3][3];
  prod_t prod_q [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[r][k] = PROD_WIDTH'(diff_q[k]) * PROD_WIDTH'(coeff[r][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s1_valid_q) prod_q <= prod_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum each row and round to 20 fraction bits, ties up
  // --------------------------------------------------------------------------
  localparam sum_t HALF = SUM_WIDTH'(1) << (COEFF_FRAC - 1);

  sum_t sum    [3];
  sum_t sum_sh [3];
  rnd_t rnd_d  [3];
  rnd_t rnd_q  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_WIDTH'(prod_q[r][0]) + SUM_WIDTH'(prod_q[r][1])
             + SUM_WIDTH'(prod_q[r][2]) + HALF;
      sum_sh[r] = sum[r] >>> COEFF_FRAC;
      rnd_d[r]  = sum_sh[r][RND_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go && s2_valid_q) rnd_q <= rnd_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: snap to whole numbers, then saturate
  // --------------------------------------------------------------------------
  localparam logic [COORD_FRAC:0] ONE_UNIT = (COORD_FRAC+1)'(1) << COORD_FRAC;

  logic [COORD_FRAC-1:0] frac   [3];
  logic [COORD_FRAC:0]   up_gap [3];
  snap_t                 snap   [3];
  logic                  fits   [3];
  coord_t                res_d  [3];
  logic                  sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      frac[r]   = rnd_q[r][COORD_FRAC-1:0];
      up_gap[r] = ONE_UNIT - {1'b0, frac[r]};
      snap[r]   = SNAP_WIDTH'(rnd_q[r]);
      // floor test wins over ceiling test
      if (frac[r] != '0 && frac[r] < thr_q) begin
        snap[r] = SNAP_WIDTH'(rnd_q[r]) - SNAP_WIDTH'($signed({1'b0, frac[r]}));
      end else if (frac[r] != '0 && up_gap[r] < {1'b0, thr_q}) begin
        snap[r] = SNAP_WIDTH'(rnd_q[r]) + SNAP_WIDTH'($signed({1'b0, up_gap[r]}));
      end
      fits[r] = (&snap[r][SNAP_WIDTH-1:COORD_WIDTH-1]) ||
                !(|snap[r][SNAP_WIDTH-1:COORD_WIDTH-1]);
      if (fits[r]) begin
        res_d[r] = snap[r][COORD_WIDTH-1:0];
      end else begin
        res_d[r] = snap[r][SNAP_WIDTH-1] ? COORD_MIN : COORD_MAX;
        sat_d    = 1'b1;
      end
    end
  end

  coord_t res_q [3];
  logic   sat_q;

  always_ff @(posedge clk_i) begin
    if (out_go && s3_valid_q) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign local_x_o   = res_q[0];
  assign local_y_o   = res_q[1];
  assign local_z_o   = res_q[2];
  assign saturated_o = sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted word did not enter stage 1");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q)
    else $error("input blocked while a stage is empty");

  a_stall_holds_products: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s3_go |=> s2_valid_q && $stable(prod_q[0][0]) &&
                             $stable(prod_q[1][1]) && $stable(prod_q[2][2]))
    else $error("stage 2 changed while stalled");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      local_x_o == COORD_MAX || local_x_o == COORD_MIN ||
      local_y_o == COORD_MAX || local_y_o == COORD_MIN ||
      local_z_o == COORD_MAX || local_z_o == COORD_MIN)
    else $error("saturated flag without a clamped component");

endmodule

// ----- bench/world_to_local_point_transform_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_local_point_transform_tb
// Drives world points through the transform and compares every local point
// and saturated flag with a bit-true fixed-point predictor kept in the bench.
// A short table of points runs under the reset matrix, a rounding-tie setup
// and an extreme setup; random points under random matrices, origins and snap
// thresholds follow, with random idling on both channels, one long receiver
// hold-off and one sender pause until the pipe is empty.
// ----------------------------------------------------------------------------
module world_to_local_point_transform_tb;
  import w2l_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } world_pt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } local_pt_t;

  typedef struct packed {
    world_pt_t pt;
    logic      known;
    local_pt_t want;
  } point_case_t;

  localparam int        IDLE_PCT         = 27;
  localparam int        RANDOM_PHASES    = 6;
  localparam int        POINTS_PER_PHASE = 72;
  localparam int        HOLD_OFF_CYCLES  = 60;
  localparam int        PIPE_DRAIN       = 6;
  localparam int        MAX_PRINTS       = 30;
  localparam int        PAD_ORIGIN       = CFG_DATA_WIDTH - COORD_WIDTH;
  localparam int        PAD_THRESH       = CFG_DATA_WIDTH - THR_WIDTH;
  localparam realtime   RUN_LIMIT        = 4_000_000;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED = '1;
  localparam logic [COORD_FRAC:0]      UNIT_STEP      = (COORD_FRAC+1)'(1) << COORD_FRAC;

  // Coefficients, Q2.18
  localparam coeff_t COEF_MAX      = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam coeff_t COEF_MIN      = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
  localparam coeff_t COEF_ONE      = coeff_t'(1) <<< COEFF_FRAC;
  localparam coeff_t COEF_HALF     = coeff_t'(1) <<< (COEFF_FRAC - 1);
  localparam coeff_t COEF_NEG_HALF = -COEF_HALF;

  // Coordinates, Q19.20
  localparam coord_t PT_ZERO     = '0;
  localparam coord_t PT_LSB      = 40'sd1;
  localparam coord_t PT_NEG_LSB  = -40'sd1;
  localparam coord_t PT_ONE      = coord_t'(1) <<< COORD_FRAC;
  localparam coord_t PT_ONE_LESS = PT_ONE - 40'sd1;
  localparam coord_t PT_ONE_P3   = 40'sh00_0010_0003;
  localparam coord_t PT_NONE_P5  = 40'shFF_FFF0_0005;
  localparam coord_t PT_FIVES    = 40'sh55_5555_5555;
  localparam coord_t PT_TENS     = 40'shAA_AAAA_AAAA;
  localparam coord_t PT_HALF     = 40'sh00_0008_0000;
  localparam coord_t PT_NEG_HALF = 40'shFF_FFF8_0000;
  localparam coord_t PT_TWO_LESS = 40'sh00_001F_FFFF;
  localparam coord_t PT_NTWO_P1  = 40'shFF_FFE0_0001;

  localparam local_pt_t NO_WANT = '0;

  // Directed points; typed results hold for the reset (identity) setup only
  localparam int POINT_CASES = 9;
  point_case_t point_table [POINT_CASES] = '{
    {PT_ZERO, PT_ZERO, PT_ZERO, 1'b1, PT_ZERO, PT_ZERO, PT_ZERO, 1'b0},
    {COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0},
    {COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0},
    {COORD_MAX, COORD_MIN, PT_ONE, 1'b1, COORD_MAX, COORD_MIN, PT_ONE, 1'b0},
    {PT_LSB, PT_NEG_LSB, PT_ZERO, 1'b0, NO_WANT},
    {PT_NEG_LSB, PT_LSB, PT_ONE_LESS, 1'b0, NO_WANT},
    {PT_ONE_P3, PT_NONE_P5, PT_FIVES, 1'b0, NO_WANT},
    {PT_TENS, PT_HALF, PT_NEG_HALF, 1'b0, NO_WANT},
    {PT_TWO_LESS, PT_NTWO_P1, PT_LSB, 1'b0, NO_WANT}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  coord_t                    world_x_i;
  coord_t                    world_y_i;
  coord_t                    world_z_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  coord_t                    local_x_o;
  coord_t                    local_y_o;
  coord_t                    local_z_o;
  logic                      saturated_o;

  // Shadow of the configuration registers
  row_t   matrix_rows [3];
  coord_t origin_pt [3];
  thr_t   snap_thr;

  local_pt_t local_expect_q [$];
  int        mismatch_count = 0;
  bit        in_idle_on;
  bit        out_idle_on;
  int        hold_off_req = 0;

  world_to_local_point_transform i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .world_x_i   (world_x_i),
    .world_y_i   (world_y_i),
    .world_z_i   (world_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .local_x_o   (local_x_o),
    .local_y_o   (local_y_o),
    .local_z_o   (local_z_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("world_to_local_point_transform_tb failed");
    $finish;
  end

  // L = M * (P - O): exact sum, round half up, snap, saturate
  function automatic local_pt_t transform_point(input world_pt_t p);
    logic signed [127:0] acc, term, pw, ow, half_lsb, hi_lim, lo_lim;
    logic [COORD_FRAC:0] frac, gap;
    coord_t              pv [3];
    coord_t              res [3];
    coeff_t              c;
    logic                sat;
    int                  i, k;
    local_pt_t           r;
    pv[0]    = p.x;
    pv[1]    = p.y;
    pv[2]    = p.z;
    sat      = 1'b0;
    half_lsb = 128'sd1;
    half_lsb = half_lsb <<< (COEFF_FRAC - 1);
    hi_lim   = 128'(COORD_MAX);
    lo_lim   = 128'(COORD_MIN);
    for (i = 0; i < 3; i++) begin
      acc = '0;
      for (k = 0; k < 3; k++) begin
        c    = matrix_rows[i][SLOT_WIDTH*k +: COEFF_WIDTH];
        term = 128'(c);
        pw   = 128'(pv[k]);
        ow   = 128'(origin_pt[k]);
        acc  = acc + term * (pw - ow);
      end
      acc  = (acc + half_lsb) >>> COEFF_FRAC;
      // snap to a whole number within the threshold; the floor test wins
      frac = {1'b0, acc[COORD_FRAC-1:0]};
      gap  = UNIT_STEP - frac;
      if (frac != 0) begin
        if (frac < snap_thr) begin
          term = 128'(frac);
          acc  = acc - term;
        end else if (gap < snap_thr) begin
          term = 128'(gap);
          acc  = acc + term;
        end
      end
      if (acc > hi_lim) begin
        res[i] = COORD_MAX;
        sat    = 1'b1;
      end else if (acc < lo_lim) begin
        res[i] = COORD_MIN;
        sat    = 1'b1;
      end else begin
        res[i] = acc[COORD_WIDTH-1:0];
      end
    end
    r.x   = res[0];
    r.y   = res[1];
    r.z   = res[2];
    r.sat = sat;
    return r;
  endfunction

  function automatic row_t pack_row(input coeff_t c0, input coeff_t c1, input coeff_t c2);
    return {c2, c1, c0};
  endfunction

  function automatic coeff_t pick_coeff(input int kind);
    coeff_t c;
    if ($urandom_range(15) == 0) begin
      c = $urandom_range(1) ? COEF_MAX : COEF_MIN;
    end else begin
      case (kind)
        0:       c = coeff_t'($urandom);
        1:       c = coeff_t'(($signed($urandom_range(4)) - 2) * COEF_ONE);
        default: c = coeff_t'($signed($urandom_range(1 << (COEFF_FRAC + 1))) - COEF_ONE);
      endcase
    end
    return c;
  endfunction

  function automatic world_pt_t random_point();
    coord_t    c [3];
    coord_t    whole;
    int        i;
    world_pt_t r;
    for (i = 0; i < 3; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: c[i] = coord_t'({$urandom, $urandom});
        4, 5:       c[i] = coord_t'($signed($urandom)) >>> $urandom_range(12);
        8: begin
          case ($urandom_range(4))
            0:       c[i] = COORD_MAX;
            1:       c[i] = COORD_MIN;
            2:       c[i] = PT_LSB;
            3:       c[i] = PT_NEG_LSB;
            default: c[i] = PT_ZERO;
          endcase
        end
        default: begin
          // just off a whole number
          whole = coord_t'($signed($urandom_range(4095)) - 2048);
          c[i]  = (whole <<< COORD_FRAC) + coord_t'($signed($urandom_range(64)) - 32);
        end
      endcase
    end
    r.x = c[0];
    r.y = c[1];
    r.z = c[2];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [COORD_WIDTH-1:0] got,
                                 input logic [COORD_WIDTH-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
  endtask

  // Write one register and mirror it in the shadow
  task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2:
        matrix_rows[idx[1:0]] = data[ROW_WIDTH-1:0];
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
        origin_pt[2'(idx - REG_ORIGIN_X)] = data[COORD_WIDTH-1:0];
      REG_THRESH:
        snap_thr = data[THR_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // Write all registers; junk in the unused upper bits must be dropped
  task automatic apply_config(input row_t r0, input row_t r1, input row_t r2,
                              input coord_t ox, input coord_t oy, input coord_t oz,
                              input thr_t thr);
    cfg_write(REG_ROW0, r0);
    cfg_write(REG_ROW1, r1);
    cfg_write(REG_ROW2, r2);
    cfg_write(REG_ORIGIN_X, {PAD_ORIGIN'($urandom), ox});
    cfg_write(REG_ORIGIN_Y, {PAD_ORIGIN'($urandom), oy});
    cfg_write(REG_ORIGIN_Z, {PAD_ORIGIN'($urandom), oz});
    cfg_write(REG_THRESH, {PAD_THRESH'({$urandom, $urandom}), thr});
  endtask

  task automatic randomize_config(input int kind);
    row_t   rw [3];
    coord_t og [3];
    thr_t   thr;
    int     i, k;
    for (i = 0; i < 3; i++) begin
      for (k = 0; k < 3; k++)
        rw[i][SLOT_WIDTH*k +: COEFF_WIDTH] = pick_coeff(kind);
      case ($urandom_range(3))
        0:       og[i] = coord_t'({$urandom, $urandom});
        1:       og[i] = coord_t'($signed($urandom_range(255)) - 128) <<< COORD_FRAC;
        2:       og[i] = PT_ZERO;
        default: og[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      endcase
    end
    case ($urandom_range(4))
      0:       thr = '0;
      1:       thr = thr_t'(1);
      2:       thr = thr_t'($urandom_range(1, 4096));
      3:       thr = thr_t'($urandom);
      default: thr = '1;
    endcase
    apply_config(rw[0], rw[1], rw[2], og[0], og[1], og[2], thr);
  endtask

  // Offer one word and hold it until taken
  task automatic offer_point(input world_pt_t pt, input bit typed, input local_pt_t want);
    while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    world_x_i  <= pt.x;
    world_y_i  <= pt.y;
    world_z_i  <= pt.z;
    do @(posedge clk_i); while (!in_ready_o);
    local_expect_q.push_back(typed ? want : transform_point(pt));
  endtask

  task automatic walk_point_table(input bit use_typed);
    int n;
    for (n = 0; n < POINT_CASES; n++)
      offer_point(point_table[n].pt, use_typed && point_table[n].known, point_table[n].want);
  endtask

  // Stop offering and wait for every outstanding word
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (local_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic check_word();
    local_pt_t want;
    if (local_expect_q.size() == 0) begin
      report_mismatch("unexpected word", local_x_o, '0);
    end else begin
      want = local_expect_q.pop_front();
      if (local_x_o !== want.x)
        report_mismatch("local_x", local_x_o, want.x);
      if (local_y_o !== want.y)
        report_mismatch("local_y", local_y_o, want.y);
      if (local_z_o !== want.z)
        report_mismatch("local_z", local_z_o, want.z);
      if (saturated_o !== want.sat)
        report_mismatch("saturated", COORD_WIDTH'(saturated_o), COORD_WIDTH'(want.sat));
    end
  endtask

  // Output side: check taken words, then pick ready for the next cycle
  initial begin : result_side
    int hold_left;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1)
        check_word();
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(out_idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : point_side
    int ph, it;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ROW0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    world_x_i   <= '0;
    world_y_i   <= '0;
    world_z_i   <= '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    // reset setup: identity matrix, zero origin, one-LSB threshold
    for (ph = 0; ph < 3; ph++) begin
      matrix_rows[ph]                            = '0;
      matrix_rows[ph][SLOT_WIDTH*ph + COEFF_FRAC] = 1'b1;
      origin_pt[ph]                              = '0;
    end
    snap_thr = thr_t'(1);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity: results read straight off the table
    walk_point_table(1'b1);
    drain_results();

    // half coefficients, no snapping: rounding ties go up
    apply_config(pack_row(COEF_HALF, '0, '0), pack_row('0, COEF_NEG_HALF, '0),
                 pack_row('0, '0, COEF_ONE), PT_ZERO, PT_ZERO, PT_ZERO, '0);
    walk_point_table(1'b0);
    drain_results();

    // extreme coefficients and origins, widest threshold: saturation, floor wins
    apply_config(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                 pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                 pack_row(COEF_MAX, COEF_MIN, COEF_HALF),
                 COORD_MAX, COORD_MIN, PT_ONE, '1);
    walk_point_table(1'b0);
    drain_results();

    // a write to an unmapped index must change nothing
    cfg_write(CFG_IDX_UNUSED, CFG_DATA_WIDTH'({$urandom, $urandom}));

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_idle_on  = (ph != 1);
      out_idle_on = (ph != 1);
      randomize_config(ph % 3);
      if (ph == 2)
        hold_off_req = HOLD_OFF_CYCLES;
      for (it = 0; it < POINTS_PER_PHASE; it++) begin
        if (ph == 3 && it == POINTS_PER_PHASE / 2)
          drain_results();
        offer_point(random_point(), 1'b0, NO_WANT);
      end
      drain_results();
    end

    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (local_expect_q.size() != 0)
      report_mismatch("words still expected", COORD_WIDTH'(local_expect_q.size()), '0);
    if (mismatch_count == 0)
      $display("world_to_local_point_transform_tb passed");
    else
      $display("world_to_local_point_transform_tb failed");
    $finish;
  end

endmodule
